/* rtl/core/bpk_pkg.sv */
// shared types and constants for the bipartite matching block
// command and status bundles between controller and datapath, port widths
// no dependencies
package bpk_pkg;

  localparam int IDX_W = 6;    // vertex index fields
  localparam int COL_W = 64;   // adjacency column field
  localparam int CNT_W = 7;    // counts and match size

  // configuration register indexes
  localparam logic REG_LEFT_COUNT  = 1'b0;
  localparam logic REG_RIGHT_COUNT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_col;    // store an adjacency column
    logic run_start;   // drop all matches, zero pair count and right vertex
    logic start_v;     // open search for current right vertex
    logic scan_hit;    // mark candidate visited, read its partner
    logic claim;       // free left vertex takes the current right vertex
    logic push;        // save frame, descend into partner's search
    logic pop_rd;      // read saved frame below the current one
    logic pop_claim;   // popped frame re-points its pending left vertex
    logic pop_resume;  // popped frame becomes current and resumes scanning
    logic pair_inc;
    logic next_v;
    logic emit_start;
    logic emit_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;       // a scan candidate exists
    logic part_free;   // read left vertex has no partner
    logic sp_zero;     // current frame is the root
    logic v_last;      // current right vertex is the last one
    logic emit_last;   // result being loaded is the final one
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

/* rtl/core/bpk_datapath.sv */
// datapath of the matching block: adjacency store, partner store, search stack,
// visited marks, candidate search and output register
// depends on bpk_pkg
module bpk_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpk_pkg::cmd_t                cmd_i,
  output bpk_pkg::sts_t                sts_o,
  input  logic [$clog2(((MAX_VERTICES < 64) ? MAX_VERTICES : 64) + 1)-1:0] nl_i,
  input  logic [$clog2(((MAX_VERTICES < 64) ? MAX_VERTICES : 64) + 1)-1:0] nr_i,
  input  logic [bpk_pkg::IDX_W-1:0]    column_index_i,
  input  logic [bpk_pkg::COL_W-1:0]    column_bits_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [bpk_pkg::IDX_W-1:0]    left_index_o,
  output logic                         matched_o,
  output logic [bpk_pkg::IDX_W-1:0]    partner_o,
  output logic [bpk_pkg::CNT_W-1:0]    match_size_o,
  output logic                         last_o
);
  import bpk_pkg::*;

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int IW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);

  typedef struct packed {
    logic [IW-1:0] rv;
    logic [CW-1:0] nxt;
    logic [IW-1:0] pend;
  } frame_t;

  // storage
  logic [NV-1:0] adj_mem [NV];
  logic [NV-1:0] adj_vld_q;
  logic [IW-1:0] pmem [NV];
  logic [NV-1:0] pvld_q;
  frame_t        stk_mem [NV];
  logic [NV-1:0] vis_q;

  // control registers
  logic [CW-1:0] v_q, sp_q, e_idx_q, pair_q;
  logic          out_vld_q;

  // working registers
  logic [NV-1:0] col_q;
  logic          col_vld_q;
  logic [IW-1:0] cur_rv_q;
  logic [CW-1:0] cur_nxt_q;
  logic [IW-1:0] sel_q;
  logic [IW-1:0] part_rd_q;
  logic          part_vld_rd_q;
  frame_t        stk_rd_q;

  logic [IDX_W-1:0] out_idx_q, out_part_q;
  logic             out_m_q, out_last_q;
  logic [CNT_W-1:0] out_size_q;

  // combinational
  logic [NV-1:0] col, cand, lowest;
  logic [IW-1:0] scan_sel;
  logic          load_ok;
  logic [IW-1:0] adj_raddr, part_raddr, pw_addr, pw_data;
  logic          adj_re, part_re, pw_en;
  logic [CW-1:0] e_nxt, sp_dec;

  assign load_ok = (CNT_W'(column_index_i) < CNT_W'(NV));
  assign col     = col_vld_q ? col_q : '0;
  assign e_nxt   = e_idx_q + CW'(1);
  assign sp_dec  = sp_q - CW'(1);

  // first unvisited adjoining left vertex at or after the scan point
  always_comb begin
    for (int k = 0; k < NV; k++) begin
      cand[k] = col[k] & ~vis_q[k] & (CW'(k) >= cur_nxt_q) & (CW'(k) < nl_i);
    end
    lowest   = cand & (~cand + NV'(1));
    scan_sel = '0;
    for (int k = 0; k < NV; k++) begin
      if (lowest[k]) begin
        scan_sel = scan_sel | IW'(k);
      end
    end
  end

  always_comb begin
    adj_re    = cmd_i.start_v | cmd_i.push | cmd_i.pop_resume;
    adj_raddr = v_q[IW-1:0];
    if (cmd_i.push) begin
      adj_raddr = part_rd_q;
    end else if (cmd_i.pop_resume) begin
      adj_raddr = stk_rd_q.rv;
    end
    part_re    = cmd_i.scan_hit | cmd_i.emit_start | cmd_i.emit_load;
    part_raddr = '0;
    if (cmd_i.scan_hit) begin
      part_raddr = scan_sel;
    end else if (cmd_i.emit_load) begin
      part_raddr = e_nxt[IW-1:0];
    end
    pw_en   = cmd_i.claim | cmd_i.pop_claim;
    pw_addr = cmd_i.claim ? sel_q : stk_rd_q.pend;
    pw_data = cmd_i.claim ? cur_rv_q : stk_rd_q.rv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q <= '0;
      pvld_q    <= '0;
      vis_q     <= '0;
      v_q       <= '0;
      sp_q      <= '0;
      e_idx_q   <= '0;
      pair_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load_col && load_ok) begin
        adj_vld_q[column_index_i[IW-1:0]] <= 1'b1;
      end
      if (cmd_i.run_start) begin
        pvld_q <= '0;
        pair_q <= '0;
        v_q    <= '0;
      end
      if (cmd_i.start_v) begin
        vis_q <= '0;
        sp_q  <= '0;
      end
      if (cmd_i.scan_hit) begin
        vis_q[scan_sel] <= 1'b1;
      end
      if (pw_en) begin
        pvld_q[pw_addr] <= 1'b1;
      end
      if (cmd_i.push) begin
        sp_q <= sp_q + CW'(1);
      end else if (cmd_i.pop_rd) begin
        sp_q <= sp_dec;
      end
      if (cmd_i.pair_inc) begin
        pair_q <= pair_q + CW'(1);
      end
      if (cmd_i.next_v) begin
        v_q <= v_q + CW'(1);
      end
      if (cmd_i.emit_start) begin
        e_idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        e_idx_q <= e_nxt;
      end
      if (cmd_i.emit_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // memories and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_col && load_ok) begin
      adj_mem[column_index_i[IW-1:0]] <= column_bits_i[NV-1:0];
    end
    if (adj_re) begin
      col_q     <= adj_mem[adj_raddr];
      col_vld_q <= adj_vld_q[adj_raddr];
    end
    if (pw_en) begin
      pmem[pw_addr] <= pw_data;
    end
    if (part_re) begin
      part_rd_q     <= pmem[part_raddr];
      part_vld_rd_q <= pvld_q[part_raddr];
    end
    if (cmd_i.push) begin
      stk_mem[sp_q[IW-1:0]] <= '{rv: cur_rv_q, nxt: cur_nxt_q, pend: sel_q};
    end
    if (cmd_i.pop_rd) begin
      stk_rd_q <= stk_mem[sp_dec[IW-1:0]];
    end
    if (cmd_i.start_v) begin
      cur_rv_q  <= v_q[IW-1:0];
      cur_nxt_q <= '0;
    end else if (cmd_i.scan_hit) begin
      cur_nxt_q <= CW'(scan_sel) + CW'(1);
      sel_q     <= scan_sel;
    end else if (cmd_i.push) begin
      cur_rv_q  <= part_rd_q;
      cur_nxt_q <= '0;
    end else if (cmd_i.pop_resume) begin
      cur_rv_q  <= stk_rd_q.rv;
      cur_nxt_q <= stk_rd_q.nxt;
    end
    if (cmd_i.emit_load) begin
      out_idx_q  <= IDX_W'(e_idx_q);
      out_m_q    <= part_vld_rd_q;
      out_part_q <= part_vld_rd_q ? IDX_W'(part_rd_q) : '0;
      out_size_q <= CNT_W'(pair_q);
      out_last_q <= (e_nxt == nl_i);
    end
  end

  assign sts_o = '{
    found:     |cand,
    part_free: ~part_vld_rd_q,
    sp_zero:   (sp_q == '0),
    v_last:    ((v_q + CW'(1)) == nr_i),
    emit_last: (e_nxt == nl_i),
    out_free:  (~out_vld_q | ~out_stall_i)
  };

  assign out_valid_o  = out_vld_q;
  assign left_index_o = out_idx_q;
  assign matched_o    = out_m_q;
  assign partner_o    = out_part_q;
  assign match_size_o = out_size_q;
  assign last_o       = out_last_q;

endmodule

/* rtl/core/bpk_ctrl.sv */
// controller of the matching block: sequences loads, the augmenting searches
// and the result transfers through commands to the datapath
// depends on bpk_pkg
module bpk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          mode_i,
  output logic          in_stall_o,
  input  bpk_pkg::sts_t sts_i,
  output bpk_pkg::cmd_t cmd_o
);
  import bpk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_PART,
    ST_POP,
    ST_NEXT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ret_q, ret_d;   // result carried back while unwinding

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.run_start = 1'b1;
            state_d         = ST_START;
          end else begin
            cmd_o.load_col = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd_o.start_v = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.found) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = ST_PART;
        end else if (sts_i.sp_zero) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.pop_rd = 1'b1;
          ret_d        = 1'b0;
          state_d      = ST_POP;
        end
      end
      ST_PART: begin
        if (sts_i.part_free) begin
          cmd_o.claim = 1'b1;
          if (sts_i.sp_zero) begin
            cmd_o.pair_inc = 1'b1;
            state_d        = ST_NEXT;
          end else begin
            cmd_o.pop_rd = 1'b1;
            ret_d        = 1'b1;
            state_d      = ST_POP;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_POP: begin
        if (ret_q) begin
          cmd_o.pop_claim = 1'b1;
          if (sts_i.sp_zero) begin
            cmd_o.pair_inc = 1'b1;
            state_d        = ST_NEXT;
          end else begin
            cmd_o.pop_rd = 1'b1;
          end
        end else begin
          cmd_o.pop_resume = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_NEXT: begin
        if (sts_i.v_last) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_EMIT;
        end else begin
          cmd_o.next_v = 1'b1;
          state_d      = ST_START;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* rtl/core/bipartite_matching_kuhn.sv */
// maximum bipartite matching by augmenting-path search (top level)
// holds the count registers and joins bpk_ctrl and bpk_datapath
// depends on bpk_pkg, bpk_ctrl, bpk_datapath
//
// input channel: in_valid_i / in_stall_o with mode_i, column_index_i, column_bits_i.
//   mode 0 stores one adjacency column; the next item is taken at once.
//   mode 1 runs the matching; in_stall_o stays high until the last result is loaded.
// a run makes, for each right vertex in turn, one augmenting search that visits left
//   vertices, backtracks and re-matches the saved frames while unwinding, all
//   through the single-port adjacency, partner and stack memories; then the
//   results are handed out.
// output channel: out_valid_o / out_stall_i, one transfer per left vertex in
//   ascending order, last_o on the final one. a stalled result holds in the
//   output register and the run waits for it.
// config channel: cfg_valid_i / cfg_ready_o (always ready), index 0 is
//   left_count and index 1 right_count; zero reads as 1, large values saturate.
// reset: adjacency reads as all zero, no matches, both counts at their maximum.
module bipartite_matching_kuhn #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [bpk_pkg::IDX_W-1:0]   column_index_i,
  input  logic [bpk_pkg::COL_W-1:0]   column_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bpk_pkg::IDX_W-1:0]   left_index_o,
  output logic                        matched_o,
  output logic [bpk_pkg::IDX_W-1:0]   partner_o,
  output logic [bpk_pkg::CNT_W-1:0]   match_size_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [bpk_pkg::CNT_W-1:0]   cfg_data_i
);
  import bpk_pkg::*;

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int CW = $clog2(NV + 1);

  logic [CW-1:0] left_cnt_q, right_cnt_q, cfg_cnt;
  cmd_t          cmd;
  sts_t          sts;

  assign cfg_ready_o = 1'b1;

  // zero reads as one, anything above the vertex limit saturates
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_cnt = CW'(1);
    end else if (cfg_data_i > CNT_W'(NV)) begin
      cfg_cnt = CW'(NV);
    end else begin
      cfg_cnt = CW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cnt_q  <= CW'(NV);
      right_cnt_q <= CW'(NV);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LEFT_COUNT:  left_cnt_q  <= cfg_cnt;
        REG_RIGHT_COUNT: right_cnt_q <= cfg_cnt;
        default: begin
        end
      endcase
    end
  end

  bpk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpk_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .nl_i           (left_cnt_q),
    .nr_i           (right_cnt_q),
    .column_index_i (column_index_i),
    .column_bits_i  (column_bits_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .left_index_o   (left_index_o),
    .matched_o      (matched_o),
    .partner_o      (partner_o),
    .match_size_o   (match_size_o),
    .last_o         (last_o)
  );

  // a run item keeps the input side closed on the following cycle
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i |=> in_stall_o)
    else $error("run item did not close the input side");

  // the final result belongs to the last left vertex in use
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (CNT_W'(left_index_o) + CNT_W'(1)) == CNT_W'(left_cnt_q))
    else $error("last flag on wrong left vertex");

  // a matching never exceeds either side
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_size_o <= CNT_W'(left_cnt_q)) &&
                    (match_size_o <= CNT_W'(right_cnt_q)))
    else $error("match size exceeds vertex count");

endmodule

/* test/tb_bipartite_matching_kuhn.sv */
// self-checking testbench for bipartite_matching_kuhn: directed table, then random runs
// predicts every result with its own augmenting-path search over a mirror of the block state
// depends on bpk_pkg and bipartite_matching_kuhn
module tb_bipartite_matching_kuhn;
  import bpk_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;
  localparam logic [CNT_W-1:0] UNMATCHED = 7'd127;
  localparam int NV          = 64;
  localparam int ITEM_TARGET = 280;
  localparam int SETTLE_CYC  = 8;
  localparam int END_CYC     = 50;
  localparam int LONG_HOLD   = 500;
  localparam int LIMIT       = 20000000;

  typedef struct {
    logic [IDX_W-1:0] left_index;
    logic             matched;
    logic [IDX_W-1:0] partner;
    logic [CNT_W-1:0] match_size;
    logic             last;
  } match_report_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic             reg_idx;
    logic [CNT_W-1:0] reg_val;
    logic             mode;
    logic [IDX_W-1:0] col;
    logic [COL_W-1:0] bits;
    int               typed_size;  // -1: size comes from the predictor
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             mode = 1'b0;
  logic [IDX_W-1:0] column_index = '0;
  logic [COL_W-1:0] column_bits = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] left_index;
  logic             matched;
  logic [IDX_W-1:0] partner;
  logic [CNT_W-1:0] match_size;
  logic             last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  bipartite_matching_kuhn dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .column_index_i (column_index),
    .column_bits_i  (column_bits),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_index_o   (left_index),
    .matched_o      (matched),
    .partner_o      (partner),
    .match_size_o   (match_size),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block state
  logic [COL_W-1:0] adj_mirror [NV];
  logic [CNT_W-1:0] left_mate [NV];
  bit               left_seen [NV];
  int unsigned      n_left = NV;
  int unsigned      n_right = NV;
  int unsigned      fr_right [NV+1];
  int unsigned      fr_scan [NV+1];
  int unsigned      fr_pend [NV+1];

  match_report_t awaited_reports [$];
  dir_row_t      directed_rows [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int fail_count = 0;
  int shown = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  function automatic int unsigned count_from_reg(logic [CNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > NV) return NV;
    return 32'(raw);
  endfunction

  // one depth-first augmenting search rooted at a right vertex, explicit frames
  function automatic bit search_from(int unsigned root, int unsigned nl);
    int unsigned sp;
    int unsigned top;
    int unsigned cand;
    bit have_ret;
    bit ok;
    bit descended;
    have_ret = 0;
    ok = 0;
    fr_right[0] = root;
    fr_scan[0] = 0;
    fr_pend[0] = 0;
    sp = 1;
    while (sp > 0) begin
      top = sp - 1;
      descended = 0;
      if (have_ret) begin
        have_ret = 0;
        if (ok) begin
          // child found a path: this frame's pending left vertex moves over
          left_mate[fr_pend[top]] = CNT_W'(fr_right[top]);
          sp--;
          have_ret = 1;
          continue;
        end
      end
      while (fr_scan[top] < nl) begin
        cand = fr_scan[top];
        fr_scan[top]++;
        if (!adj_mirror[fr_right[top]][cand] || left_seen[cand]) continue;
        left_seen[cand] = 1;
        if (left_mate[cand] == UNMATCHED) begin
          left_mate[cand] = CNT_W'(fr_right[top]);
          sp--;
          ok = 1;
          have_ret = 1;
          descended = 1;
          break;
        end
        fr_pend[top] = cand;
        if (sp < NV + 1) begin
          fr_right[sp] = 32'(left_mate[cand]);
          fr_scan[sp] = 0;
          fr_pend[sp] = 0;
          sp++;
        end
        descended = 1;
        break;
      end
      if (!descended) begin
        sp--;
        ok = 0;
        have_ret = 1;
      end
    end
    return ok;
  endfunction

  function automatic void predict_run(int typed_size);
    int unsigned pairs;
    match_report_t rep;
    for (int i = 0; i < NV; i++) left_mate[i] = UNMATCHED;
    pairs = 0;
    for (int unsigned v = 0; v < n_right; v++) begin
      for (int i = 0; i < NV; i++) left_seen[i] = 0;
      if (search_from(v, n_left)) pairs++;
    end
    for (int unsigned i = 0; i < n_left; i++) begin
      rep.left_index = IDX_W'(i);
      rep.matched    = (left_mate[i] != UNMATCHED);
      rep.partner    = rep.matched ? left_mate[i][IDX_W-1:0] : '0;
      rep.match_size = (typed_size >= 0) ? CNT_W'(typed_size) : CNT_W'(pairs);
      rep.last       = (i + 1 == n_left);
      awaited_reports = {awaited_reports, rep};
    end
  endfunction

  function automatic logic [COL_W-1:0] random_column();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} & {$urandom, $urandom};
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(15));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] random_count_raw(int unsigned small_max);
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return 7'd127;
    if (sel == 2) return CNT_W'($urandom_range(127));
    return CNT_W'($urandom_range(small_max, 1));
  endfunction

  function automatic void add_cfg(logic idx, logic [CNT_W-1:0] val);
    dir_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, mode: MODE_LOAD, col: '0, bits: '0,
          typed_size: -1};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_item(logic m, logic [IDX_W-1:0] c, logic [COL_W-1:0] b,
                                   int typed_size);
    dir_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: 1'b0, reg_val: '0, mode: m, col: c, bits: b,
          typed_size: typed_size};
    directed_rows = {directed_rows, r};
  endfunction

  // entered and left at a falling edge; valid stays high on return
  task automatic send_item(logic m, logic [IDX_W-1:0] c, logic [COL_W-1:0] b,
                           int typed_size);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    column_index <= c;
    column_bits <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m == MODE_LOAD) adj_mirror[c] = b;
    else predict_run(typed_size);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LEFT_COUNT) n_left = count_from_reg(val);
    else n_right = count_from_reg(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // lower valid and wait until the block has delivered everything
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when the sender asks for one
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    match_report_t exp_rep;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: left %0d matched %0d partner %0d size %0d last %0d",
                   left_index, matched, partner, match_size, last);
        end
      end else begin
        exp_rep = awaited_reports.pop_front();
        if (left_index !== exp_rep.left_index || matched !== exp_rep.matched ||
            partner !== exp_rep.partner || match_size !== exp_rep.match_size ||
            last !== exp_rep.last) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: exp left %0d matched %0d partner %0d size %0d last %0d",
                     exp_rep.left_index, exp_rep.matched, exp_rep.partner,
                     exp_rep.match_size, exp_rep.last);
            $display("          got left %0d matched %0d partner %0d size %0d last %0d",
                     left_index, matched, partner, match_size, last);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int seq;
    int unsigned nr_now;
    logic [CNT_W-1:0] l_raw;
    logic [CNT_W-1:0] r_raw;
    for (int i = 0; i < NV; i++) begin
      adj_mirror[i] = '0;
      left_mate[i] = UNMATCHED;
      left_seen[i] = 0;
    end

    // run on an empty store, then count clamping, extreme columns and re-augmenting
    add_item(MODE_RUN, 6'd0, 64'd0, 0);
    add_cfg(REG_LEFT_COUNT, 7'd0);
    add_cfg(REG_RIGHT_COUNT, 7'd0);
    add_item(MODE_LOAD, 6'd0, '1, -1);
    add_item(MODE_RUN, 6'd0, 64'd0, 1);
    add_cfg(REG_LEFT_COUNT, 7'd127);
    add_cfg(REG_RIGHT_COUNT, 7'd100);
    add_item(MODE_LOAD, 6'd63, '1, -1);
    add_item(MODE_RUN, 6'd63, '1, 2);
    add_cfg(REG_LEFT_COUNT, 7'd2);
    add_cfg(REG_RIGHT_COUNT, 7'd2);
    add_item(MODE_LOAD, 6'd0, 64'h3, -1);
    add_item(MODE_LOAD, 6'd1, 64'h1, -1);
    add_item(MODE_RUN, 6'd0, 64'd0, 2);
    // bits only above left_count are kept but play no part
    add_cfg(REG_LEFT_COUNT, 7'd3);
    add_cfg(REG_RIGHT_COUNT, 7'd3);
    add_item(MODE_LOAD, 6'd2, 64'hFFFF_FFFF_FFFF_FFF8, -1);
    add_item(MODE_RUN, 6'd0, 64'd0, 2);
    // lower triangle forces a chain of re-augmenting searches
    add_cfg(REG_LEFT_COUNT, 7'd4);
    add_cfg(REG_RIGHT_COUNT, 7'd4);
    add_item(MODE_LOAD, 6'd0, 64'h1, -1);
    add_item(MODE_LOAD, 6'd1, 64'h3, -1);
    add_item(MODE_LOAD, 6'd2, 64'h7, -1);
    add_item(MODE_LOAD, 6'd3, 64'hF, -1);
    add_item(MODE_RUN, 6'd0, 64'd0, 4);
    add_item(MODE_LOAD, 6'd1, 64'd0, -1);
    add_item(MODE_RUN, 6'd0, 64'd0, -1);
    add_cfg(REG_LEFT_COUNT, 7'd64);
    add_cfg(REG_RIGHT_COUNT, 7'd64);
    add_item(MODE_RUN, 6'd0, 64'd0, -1);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 12;
    stall_pct = 12;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
      end else begin
        send_item(directed_rows[k].mode, directed_rows[k].col, directed_rows[k].bits,
                  directed_rows[k].typed_size);
      end
    end

    // random part: configure, load the columns in use, run; some noise in between
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      case (seq % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      settle();
      l_raw = random_count_raw(16);
      r_raw = random_count_raw(10);
      write_reg(REG_LEFT_COUNT, l_raw);
      write_reg(REG_RIGHT_COUNT, r_raw);
      nr_now = n_right;
      for (int unsigned v = 0; v < nr_now; v++) begin
        if ($urandom_range(9) == 0)
          send_item(MODE_LOAD, IDX_W'($urandom_range(63)), random_column(), -1);
        if ($urandom_range(11) != 0)
          send_item(MODE_LOAD, IDX_W'(v), random_column(), -1);
      end
      if (seq == 3) hold_requests++;
      send_item(MODE_RUN, IDX_W'($urandom_range(63)), random_column(), -1);
      if (seq == 3) begin
        // the results wait behind the hold-off and the input stalls
        repeat (3) send_item(MODE_LOAD, IDX_W'($urandom_range(63)), random_column(), -1);
      end
      if ($urandom_range(6) == 0)
        send_item(MODE_RUN, IDX_W'($urandom_range(63)), random_column(), -1);
      seq++;
    end

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (END_CYC) @(posedge clk);
    fail_count += awaited_reports.size();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
